// ----- hw/rtl/pva_pkg.sv -----
// pva_pkg: beat types, op and kind codes and constants for the voice allocator
// no dependencies

package pva_pkg;

    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [1:0] OP_PEDAL    = 2'd2;
    localparam logic [1:0] OP_ENV_DONE = 2'd3;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_REUSE  = 2'd1;
    localparam logic [1:0] KIND_IDLE   = 2'd2;
    localparam logic [1:0] KIND_STEAL  = 2'd3;

    localparam logic [6:0] PEDAL_THRESHOLD = 7'd64;
    localparam logic [6:0] RESET_NOTE      = 7'd60;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [6:0] pedal_level;
        logic [2:0] voice_index;
    } cmd_t;

    typedef struct packed {
        logic [2:0] assigned_voice;
        logic [1:0] assign_kind;
        logic [6:0] assigned_note;
        logic [6:0] assigned_velocity;
        logic [5:0] gate_mask;
        logic [5:0] key_mask;
        logic [5:0] active_mask;
        logic       sustain_held;
    } status_t;

    typedef struct packed {
        logic reuse;
        logic idle;
        logic release_hit;
    } match_t;

endpackage

// ----- hw/rtl/pva_match.sv -----
// pva_match: shared note compare and voice flag test, used once per scan cycle
// depends on pva_pkg

module pva_match (
    input  logic [6:0]      voice_note,
    input  logic [6:0]      note,
    input  logic            active,
    input  logic            key,
    output pva_pkg::match_t result
);

    logic note_eq;

    assign note_eq            = (voice_note == note);
    assign result.reuse       = note_eq && (active || key);
    assign result.idle        = !active && !key;
    assign result.release_hit = note_eq && key;

endmodule

// ----- hw/rtl/poly_voice_allocator_sustain.sv -----
// poly_voice_allocator_sustain: polyphonic voice allocator with sustain pedal
// depends on pva_pkg and pva_match
//
//   channel   dir   handshake              beat
//   cmd       in    cmd_valid / cmd_stall  pva_pkg::cmd_t
//   res       out   res_valid / res_stall  pva_pkg::status_t
//
// note on and note off scan one voice per cycle through the shared compare unit;
// an allocating note on then writes the chosen voice, pedal and envelope beats
// skip the scan, and the result waits in S_OUT while res is stalled
// cmd is stalled while a beat is in work; the res register frees the scan
// reset gives note 60, zero velocity, all flags low, pointer zero, pedal up

module poly_voice_allocator_sustain #(
    parameter int VOICES = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  pva_pkg::cmd_t     cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output pva_pkg::status_t  res
);

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int PAD_W = (VOICES > 6) ? VOICES : 6;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_RELEASE,
        S_WRITE,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic [6:0]         voice_note_reg [VOICES];
    logic [6:0]         voice_note_next [VOICES];
    logic [6:0]         voice_vel_reg [VOICES];
    logic [6:0]         voice_vel_next [VOICES];
    logic [VOICES-1:0]  active_reg, active_next;
    logic [VOICES-1:0]  gate_reg, gate_next;
    logic [VOICES-1:0]  key_reg, key_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic               pedal_reg, pedal_next;
    logic [6:0]         note_reg, note_next;
    logic [6:0]         vel_reg, vel_next;
    logic               reuse_found_reg, reuse_found_next;
    logic [IDX_W-1:0]   reuse_idx_reg, reuse_idx_next;
    logic               idle_found_reg, idle_found_next;
    logic [IDX_W-1:0]   idle_idx_reg, idle_idx_next;
    logic [IDX_W-1:0]   av_reg, av_next;
    logic [1:0]         kind_reg, kind_next;
    logic               res_valid_reg, res_valid_next;
    pva_pkg::status_t   res_reg, res_next;

    pva_pkg::match_t    hit;
    logic [PAD_W-1:0]   gate_pad, key_pad, active_pad;

    pva_match u_match (
        .voice_note (voice_note_reg[scan_reg]),
        .note       (note_reg),
        .active     (active_reg[scan_reg]),
        .key        (key_reg[scan_reg]),
        .result     (hit)
    );

    assign gate_pad   = PAD_W'(gate_reg);
    assign key_pad    = PAD_W'(key_reg);
    assign active_pad = PAD_W'(active_reg);

    always_comb
    begin
        logic [IDX_W-1:0] sel;
        logic             down;

        state_next       = state_reg;
        scan_next        = scan_reg;
        voice_note_next  = voice_note_reg;
        voice_vel_next   = voice_vel_reg;
        active_next      = active_reg;
        gate_next        = gate_reg;
        key_next         = key_reg;
        ptr_next         = ptr_reg;
        pedal_next       = pedal_reg;
        note_next        = note_reg;
        vel_next         = vel_reg;
        reuse_found_next = reuse_found_reg;
        reuse_idx_next   = reuse_idx_reg;
        idle_found_next  = idle_found_reg;
        idle_idx_next    = idle_idx_reg;
        av_next          = av_reg;
        kind_next        = kind_reg;
        res_valid_next   = res_valid_reg && res_stall;
        res_next         = res_reg;
        sel              = ptr_reg;
        down             = (cmd.pedal_level >= pva_pkg::PEDAL_THRESHOLD);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    note_next        = cmd.note;
                    vel_next         = cmd.velocity;
                    scan_next        = '0;
                    reuse_found_next = 1'b0;
                    idle_found_next  = 1'b0;
                    av_next          = '0;
                    kind_next        = pva_pkg::KIND_NONE;
                    unique case (cmd.op)
                        pva_pkg::OP_NOTE_ON:
                        begin
                            if (cmd.velocity != 7'd0)
                                state_next = S_ALLOC;
                            else
                                state_next = S_RELEASE;
                        end
                        pva_pkg::OP_NOTE_OFF:
                        begin
                            state_next = S_RELEASE;
                        end
                        pva_pkg::OP_PEDAL:
                        begin
                            if (down && !pedal_reg)
                                pedal_next = 1'b1;
                            else if (!down && pedal_reg)
                            begin
                                pedal_next = 1'b0;
                                gate_next  = gate_reg & key_reg;
                            end
                            state_next = S_OUT;
                        end
                        pva_pkg::OP_ENV_DONE:
                        begin
                            for (int i = 0; i < VOICES; i++)
                            begin
                                if (int'(cmd.voice_index) == i && !gate_reg[i] && !key_reg[i])
                                    active_next[i] = 1'b0;
                            end
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (hit.reuse && !reuse_found_reg)
                begin
                    reuse_found_next = 1'b1;
                    reuse_idx_next   = scan_reg;
                end
                if (hit.idle && !idle_found_reg)
                begin
                    idle_found_next = 1'b1;
                    idle_idx_next   = scan_reg;
                end
                if (scan_reg == LAST_IDX)
                    state_next = S_WRITE;
                else
                    scan_next = scan_reg + 1'b1;
            end
            S_WRITE:
            begin
                if (reuse_found_reg)
                begin
                    sel       = reuse_idx_reg;
                    kind_next = pva_pkg::KIND_REUSE;
                end
                else if (idle_found_reg)
                begin
                    sel       = idle_idx_reg;
                    kind_next = pva_pkg::KIND_IDLE;
                end
                else
                begin
                    sel       = ptr_reg;
                    kind_next = pva_pkg::KIND_STEAL;
                    ptr_next  = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                end
                voice_note_next[sel] = note_reg;
                voice_vel_next[sel]  = vel_reg;
                active_next[sel]     = 1'b1;
                gate_next[sel]       = 1'b1;
                key_next[sel]        = 1'b1;
                av_next              = sel;
                state_next           = S_OUT;
            end
            S_RELEASE:
            begin
                if (hit.release_hit)
                begin
                    key_next[scan_reg] = 1'b0;
                    if (!pedal_reg)
                        gate_next[scan_reg] = 1'b0;
                end
                if (scan_reg == LAST_IDX)
                    state_next = S_OUT;
                else
                    scan_next = scan_reg + 1'b1;
            end
            S_OUT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next             = 1'b1;
                    res_next.assigned_voice    = 3'(av_reg);
                    res_next.assign_kind       = kind_reg;
                    res_next.assigned_note     =
                        (kind_reg == pva_pkg::KIND_NONE) ? 7'd0 : note_reg;
                    res_next.assigned_velocity =
                        (kind_reg == pva_pkg::KIND_NONE) ? 7'd0 : vel_reg;
                    res_next.gate_mask         = gate_pad[5:0];
                    res_next.key_mask          = key_pad[5:0];
                    res_next.active_mask       = active_pad[5:0];
                    res_next.sustain_held      = pedal_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            scan_reg        <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                voice_note_reg[i] <= pva_pkg::RESET_NOTE;
                voice_vel_reg[i]  <= 7'd0;
            end
            active_reg      <= '0;
            gate_reg        <= '0;
            key_reg         <= '0;
            ptr_reg         <= '0;
            pedal_reg       <= 1'b0;
            reuse_found_reg <= 1'b0;
            idle_found_reg  <= 1'b0;
            av_reg          <= '0;
            kind_reg        <= pva_pkg::KIND_NONE;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_reg        <= scan_next;
            voice_note_reg  <= voice_note_next;
            voice_vel_reg   <= voice_vel_next;
            active_reg      <= active_next;
            gate_reg        <= gate_next;
            key_reg         <= key_next;
            ptr_reg         <= ptr_next;
            pedal_reg       <= pedal_next;
            reuse_found_reg <= reuse_found_next;
            idle_found_reg  <= idle_found_next;
            av_reg          <= av_next;
            kind_reg        <= kind_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg      <= note_next;
        vel_reg       <= vel_next;
        reuse_idx_reg <= reuse_idx_next;
        idle_idx_reg  <= idle_idx_next;
        res_reg       <= res_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
